// ----- rtl/lapic_tmr_pkg.sv -----
// Shared types, register offsets and helpers for the local APIC countdown timer.
package lapic_tmr_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int DATA_WIDTH  = 32;
    localparam int OFF_WIDTH   = 12;
    localparam int PRESC_WIDTH = 7;
    localparam int DIV_WIDTH   = PRESC_WIDTH + 1;

    localparam logic [OFF_WIDTH-1:0] OFF_LVT  = 12'h320;
    localparam logic [OFF_WIDTH-1:0] OFF_INIT = 12'h380;
    localparam logic [OFF_WIDTH-1:0] OFF_CURR = 12'h390;
    localparam logic [OFF_WIDTH-1:0] OFF_DIV  = 12'h3E0;

    localparam int LVT_MASK_BIT     = 16;
    localparam int LVT_PERIODIC_BIT = 17;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  timer_fired;
        logic [7:0]            fired_vector;
    } t_result;

    // Divide code bits {3,1,0}: 000 /2 ... 110 /128, 111 /1.
    function automatic logic [DIV_WIDTH-1:0] divisor(input logic [3:0] code);
        logic [2:0]           sel;
        logic [DIV_WIDTH-1:0] div;
        sel = {code[3], code[1:0]};
        if (sel == 3'b111) begin
            div = DIV_WIDTH'(1);
        end else begin
            div = DIV_WIDTH'(2) << sel;
        end
        return div;
    endfunction

endpackage

// ----- rtl/lapic_tmr_regs.sv -----
// Timer register file and single-pass tick/access update logic.
module lapic_tmr_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [1:0]                         i_command,
    input  logic [lapic_tmr_pkg::OFF_WIDTH-1:0]  i_reg_offset,
    input  logic [lapic_tmr_pkg::DATA_WIDTH-1:0] i_write_data,
    output lapic_tmr_pkg::t_result             o_result
);
    import lapic_tmr_pkg::*;

    logic [7:0]             r_vector, n_vector;
    logic                   r_masked, n_masked;
    logic                   r_periodic, n_periodic;
    logic [3:0]             r_div_code, n_div_code;
    logic [COUNT_WIDTH-1:0] r_init, n_init;
    logic [COUNT_WIDTH-1:0] r_curr, n_curr;
    logic [PRESC_WIDTH-1:0] r_presc, n_presc;

    logic [DIV_WIDTH-1:0]   presc_next;
    t_result                res;

    assign presc_next = {1'b0, r_presc} + DIV_WIDTH'(1);

    always_comb begin
        n_vector   = r_vector;
        n_masked   = r_masked;
        n_periodic = r_periodic;
        n_div_code = r_div_code;
        n_init     = r_init;
        n_curr     = r_curr;
        n_presc    = r_presc;
        res        = '0;
        unique case (i_command)
            CMD_TICK: begin
                if (r_curr != '0) begin
                    if (presc_next >= divisor(r_div_code)) begin
                        n_presc = '0;
                        if (r_curr == COUNT_WIDTH'(1)) begin
                            res.timer_fired  = !r_masked;
                            res.fired_vector = r_masked ? 8'd0 : r_vector;
                            n_curr           = r_periodic ? r_init : '0;
                        end else begin
                            n_curr = r_curr - COUNT_WIDTH'(1);
                        end
                    end else begin
                        n_presc = presc_next[PRESC_WIDTH-1:0];
                    end
                end
            end
            CMD_WRITE: begin
                unique case (i_reg_offset)
                    OFF_LVT: begin
                        n_vector   = i_write_data[7:0];
                        n_masked   = i_write_data[LVT_MASK_BIT];
                        n_periodic = i_write_data[LVT_PERIODIC_BIT];
                    end
                    OFF_INIT: begin
                        n_init  = i_write_data[COUNT_WIDTH-1:0];
                        n_curr  = i_write_data[COUNT_WIDTH-1:0];
                        n_presc = '0;
                    end
                    OFF_DIV: begin
                        n_div_code = {i_write_data[3], 1'b0, i_write_data[1:0]};
                    end
                    default: ;
                endcase
            end
            CMD_READ: begin
                unique case (i_reg_offset)
                    OFF_LVT: begin
                        res.read_data = {14'd0, r_periodic, r_masked, 8'd0, r_vector};
                    end
                    OFF_INIT: res.read_data = DATA_WIDTH'(r_init);
                    OFF_CURR: res.read_data = DATA_WIDTH'(r_curr);
                    OFF_DIV:  res.read_data = DATA_WIDTH'(r_div_code);
                    default:  ;
                endcase
            end
            default: ;
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector   <= '0;
            r_masked   <= 1'b1;
            r_periodic <= 1'b0;
            r_div_code <= '0;
            r_init     <= '0;
            r_curr     <= '0;
            r_presc    <= '0;
        end else if (i_accept) begin
            r_vector   <= n_vector;
            r_masked   <= n_masked;
            r_periodic <= n_periodic;
            r_div_code <= n_div_code;
            r_init     <= n_init;
            r_curr     <= n_curr;
            r_presc    <= n_presc;
        end
    end

endmodule

// ----- rtl/local_apic_countdown_timer_top.sv -----
// Top level of the local APIC countdown timer: handshakes and result register.
// Each accepted beat (tick, register write or register read) updates the timer
// state in the cycle it is accepted and yields exactly one result beat in the
// output register on the next cycle. One beat per clock is sustained; the
// input stays ready while a held result is taken in the same cycle, so the
// only stall comes from the output side holding i_out_ready low.
module local_apic_countdown_timer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_command,
    input  logic [lapic_tmr_pkg::OFF_WIDTH-1:0]  i_reg_offset,
    input  logic [lapic_tmr_pkg::DATA_WIDTH-1:0] i_write_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [lapic_tmr_pkg::DATA_WIDTH-1:0] o_read_data,
    output logic                                 o_timer_fired,
    output logic [7:0]                           o_fired_vector
);
    import lapic_tmr_pkg::*;

    logic    accept;
    logic    r_out_valid;
    t_result r_out;
    t_result result;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    lapic_tmr_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_command    (i_command),
        .i_reg_offset (i_reg_offset),
        .i_write_data (i_write_data),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out.read_data;
    assign o_timer_fired  = r_out.timer_fired;
    assign o_fired_vector = r_out.fired_vector;

endmodule

// ----- rtl/lapic_tmr_checker.sv -----
// Port-level checker for the local APIC countdown timer, bound to the top level.
module lapic_tmr_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic [1:0]                           i_command,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic [lapic_tmr_pkg::DATA_WIDTH-1:0] o_read_data,
    input logic                                 o_timer_fired,
    input logic [7:0]                           o_fired_vector
);
    import lapic_tmr_pkg::*;

    // every accepted beat shows a result on the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("accepted beat produced no result");

    // only ticks can fire
    a_access_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_command != CMD_TICK) |=> !o_timer_fired)
        else $error("register access fired the timer");

    a_vector_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_timer_fired) |-> (o_fired_vector == 8'd0))
        else $error("vector nonzero without fire");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_data) && $stable(o_timer_fired)
             && $stable(o_fired_vector)))
        else $error("stalled result beat changed");

endmodule

bind local_apic_countdown_timer_top lapic_tmr_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_command      (i_command),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_read_data    (o_read_data),
    .o_timer_fired  (o_timer_fired),
    .o_fired_vector (o_fired_vector)
);
